// ----- src/sld_pkg.sv -----
// Shared definitions for the sticky least-loaded dispatch unit.
// Field widths, default sizes, controller states and the command/status bundles.
// No dependencies.
package sld_pkg;

    localparam int SOURCE_SLOTS_DEF = 64;
    localparam int QUEUE_COUNT_DEF  = 8;

    localparam int SRC_W       = 16;
    localparam int QIDX_W      = 3;
    localparam int LOAD_W      = 7;
    localparam int CFG_W       = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic [LOAD_W-1:0] LOAD_MAX   = 7'd127;
    localparam logic [CFG_W-1:0]  ACTIVE_RST = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MIN,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic search_start;
        logic search_step;
        logic min_start;
        logic min_step;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic min_done;
        logic out_free;
    } status_t;

endpackage

// ----- src/sticky_least_loaded_dispatch_unit.sv -----
// Top level of the sticky least-loaded dispatch unit.
// Depends on sld_pkg, sld_ctrl, sld_dpath (which holds two sld_ram instances).
//
//  Channel  Direction  Handshake            Payload (lowest bit first)
//  s_       in         s_tvalid/s_tready    s_tdata[15:0] source_id
//  m_       out        m_tvalid/m_tready    m_tdata[2:0] queue_index, [3] new_assignment,
//                                           [4] table_full, [7:5] zero
//  cfg_     in         cfg_valid/cfg_ready  cfg_data[3:0] active_queues
//
// One item is in flight at a time. A known source is found by a one-entry-per-cycle scan
// of the affinity table RAM up to its slot; a new source scans all used table slots and
// then the load RAM of the active queues in the same way. The table uses a fill count
// and the loads use per-queue valid bits, so no clearing pass follows reset; aresetn
// is synchronous and active low. A finished result sits in the output register; a
// stalled m_tready holds only the final hand-off, and the input side takes the next
// item once the result is loaded.
module sticky_least_loaded_dispatch_unit #(
    parameter int SOURCE_SLOTS = sld_pkg::SOURCE_SLOTS_DEF,
    parameter int QUEUE_COUNT  = sld_pkg::QUEUE_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Source item: [15:0] source_id.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sld_pkg::IN_TDATA_W-1:0]    s_tdata,
    // Result: [2:0] queue_index, [3] new_assignment, [4] table_full, [7:5] zero.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sld_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // Configuration write: active_queues.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sld_pkg::CFG_W-1:0]         cfg_data
);
    import sld_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller only sequences; all table, load and result state lives in the datapath.
    sld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sld_dpath #(
        .SOURCE_SLOTS (SOURCE_SLOTS),
        .QUEUE_COUNT  (QUEUE_COUNT)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- src/sld_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the affinity table and the queue load counters.
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sld_ctrl.sv -----
// Sequencing controller: lookup, least-loaded scan, table update, result hand-off.
// Depends on sld_pkg for the state type and the command/status bundles.
module sld_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sld_pkg::status_t status,
    output sld_pkg::cmd_t    cmd
);
    import sld_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.search_start = 1'b1;
                    state_next       = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // The datapath captures the stored queue on the step that sees a hit.
                cmd.search_step = 1'b1;
                if (status.hit) begin
                    state_next = ST_FINISH;
                end else if (status.miss) begin
                    cmd.min_start = 1'b1;
                    state_next    = ST_MIN;
                end
            end
            ST_MIN: begin
                cmd.min_step = 1'b1;
                if (status.min_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/sld_dpath.sv -----
// Datapath: affinity table search, sequential argmin over queue loads, updates,
// configuration register and the output register. Depends on sld_pkg and sld_ram.
module sld_dpath #(
    parameter int SOURCE_SLOTS = sld_pkg::SOURCE_SLOTS_DEF,
    parameter int QUEUE_COUNT  = sld_pkg::QUEUE_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [sld_pkg::IN_TDATA_W-1:0]     in_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sld_pkg::CFG_W-1:0]          cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sld_pkg::OUT_TDATA_W-1:0]    out_data,
    input  sld_pkg::cmd_t                      cmd,
    output sld_pkg::status_t                   status
);
    import sld_pkg::*;

    localparam int UW  = $clog2(SOURCE_SLOTS + 1);
    localparam int SAW = $clog2(SOURCE_SLOTS);
    localparam int QCW = $clog2(QUEUE_COUNT + 1);
    localparam int QAW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int CW  = (QCW > CFG_W) ? QCW : CFG_W;
    localparam int SLOT_W = SRC_W + QIDX_W;

    logic [CFG_W-1:0]       active_reg;
    logic [SRC_W-1:0]       src_reg;
    logic [UW-1:0]          used_reg;
    logic [UW-1:0]          cnt_reg;
    logic                   rv_reg;
    logic [QCW-1:0]         lcnt_reg;
    logic                   lrv_reg;
    logic [QAW-1:0]         la_reg;
    logic [LOAD_W-1:0]      best_reg;
    logic [QAW-1:0]         best_idx_reg;
    logic [QUEUE_COUNT-1:0] lvalid_reg;
    logic [QIDX_W-1:0]      res_q_reg;
    logic                   res_new_reg;
    logic                   res_full_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [SLOT_W-1:0]      slot_rdata;
    logic [LOAD_W-1:0]      load_rdata;
    logic [LOAD_W-1:0]      load_val;
    logic [LOAD_W-1:0]      load_inc;
    logic [CW-1:0]          act_w;
    logic [CW-1:0]          qc_w;
    logic [CW-1:0]          n_w;
    logic [QCW-1:0]         n_active;
    logic                   full;
    logic                   match;
    logic                   slot_re;
    logic                   load_re;
    logic                   upd_we;
    logic [QAW+QIDX_W-1:0]  best_ext;
    logic [QIDX_W-1:0]      best_q;

    // Effective active count: zero acts as one, large values saturate.
    assign act_w    = CW'(active_reg);
    assign qc_w     = CW'(QUEUE_COUNT);
    assign n_w      = (act_w == '0) ? CW'(1) : ((act_w > qc_w) ? qc_w : act_w);
    assign n_active = n_w[QCW-1:0];

    // Slots fill from the bottom and are never freed, so the fill count is the free slot.
    assign full     = (used_reg == UW'(SOURCE_SLOTS));
    assign match    = (slot_rdata[SLOT_W-1:QIDX_W] == src_reg);
    assign slot_re  = cmd.search_step && (cnt_reg < used_reg);
    assign load_re  = cmd.min_step && (lcnt_reg < n_active);
    assign upd_we   = cmd.commit && !full;
    assign load_val = lvalid_reg[la_reg] ? load_rdata : '0;
    assign load_inc = (best_reg == LOAD_MAX) ? best_reg : best_reg + LOAD_W'(1);
    assign best_ext = {{QIDX_W{1'b0}}, best_idx_reg};
    assign best_q   = best_ext[QIDX_W-1:0];

    sld_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SOURCE_SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (upd_we),
        .waddr (used_reg[SAW-1:0]),
        .wdata ({src_reg, best_q}),
        .re    (slot_re),
        .raddr (cnt_reg[SAW-1:0]),
        .rdata (slot_rdata)
    );

    sld_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (QUEUE_COUNT)
    ) u_load_ram (
        .clk   (aclk),
        .we    (upd_we),
        .waddr (best_idx_reg),
        .wdata (load_inc),
        .re    (load_re),
        .raddr (lcnt_reg[QAW-1:0]),
        .rdata (load_rdata)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= ACTIVE_RST;
            used_reg      <= '0;
            cnt_reg       <= '0;
            rv_reg        <= 1'b0;
            lcnt_reg      <= '0;
            lrv_reg       <= 1'b0;
            lvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                active_reg <= cfg_data;
            end
            if (cmd.search_start) begin
                cnt_reg <= '0;
                rv_reg  <= 1'b0;
            end else if (cmd.search_step) begin
                rv_reg <= slot_re;
                if (slot_re) begin
                    cnt_reg <= cnt_reg + UW'(1);
                end
            end
            if (cmd.min_start) begin
                lcnt_reg <= '0;
                lrv_reg  <= 1'b0;
            end else if (cmd.min_step) begin
                lrv_reg <= load_re;
                if (load_re) begin
                    lcnt_reg <= lcnt_reg + QCW'(1);
                end
            end
            if (upd_we) begin
                used_reg                 <= used_reg + UW'(1);
                lvalid_reg[best_idx_reg] <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.search_start) begin
            src_reg <= in_data[SRC_W-1:0];
        end
        if (cmd.min_step && load_re) begin
            la_reg <= lcnt_reg[QAW-1:0];
        end
        if (cmd.min_step && lrv_reg) begin
            if ((la_reg == '0) || (load_val < best_reg)) begin
                best_reg     <= load_val;
                best_idx_reg <= la_reg;
            end
        end
        if (cmd.search_step && rv_reg && match) begin
            res_q_reg    <= slot_rdata[QIDX_W-1:0];
            res_new_reg  <= 1'b0;
            res_full_reg <= 1'b0;
        end
        if (cmd.commit) begin
            res_q_reg    <= best_q;
            res_new_reg  <= !full;
            res_full_reg <= full;
        end
        if (cmd.out_load) begin
            out_data_reg <= {{(OUT_TDATA_W - QIDX_W - 2){1'b0}},
                             res_full_reg, res_new_reg, res_q_reg};
        end
    end

    assign status.hit      = rv_reg && match;
    assign status.miss     = !rv_reg && (cnt_reg == used_reg);
    assign status.min_done = !lrv_reg && (lcnt_reg == n_active);
    assign status.out_free = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/sld_checker.sv -----
// Port-level checks for the sticky least-loaded dispatch unit, bound to the top level.
// Depends on sld_pkg for the port widths.
module sld_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [sld_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                              cfg_valid,
    input logic                              cfg_ready
);
    import sld_pkg::*;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A source is either newly assigned or rejected for a full table, never both.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("new_assignment and table_full both set");

    // Only one item is in flight: after a transfer in, the input side closes.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // The padding bits above the result fields stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:QIDX_W+2] == '0))
        else $error("result padding not zero");

    // The configuration register accepts a write whenever one is offered.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind sticky_least_loaded_dispatch_unit sld_checker u_sld_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the sticky least-loaded dispatch unit: source items on s_,
// routing results on m_, active_queues writes on cfg_, checked against an in-bench predictor.
// Depends on sld_pkg and the RTL of sticky_least_loaded_dispatch_unit.
module tb;
    import sld_pkg::*;

    localparam int SLOTS          = SOURCE_SLOTS_DEF;
    localparam int QUEUES         = QUEUE_COUNT_DEF;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_ITEMS    = 50;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 100;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [QIDX_W-1:0] queue;
        logic              fresh;
        logic              full;
    } route_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [SRC_W-1:0] value;
        bit               typed;
        route_t           want;
    } dir_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // Predictor copy of the affinity table, the loads and the register.
    bit                slot_taken [SLOTS];
    logic [SRC_W-1:0]  slot_src   [SLOTS];
    logic [QIDX_W-1:0] slot_q     [SLOTS];
    logic [LOAD_W-1:0] q_load     [QUEUES];
    logic [CFG_W-1:0]  active_cfg;
    int                slots_filled;

    route_t            pending_routes [$];
    logic [SRC_W-1:0]  id_pool        [$];
    dir_row_t          directed_rows  [$];

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int route_errors  = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int fresh_seen    = 0;
    int hit_seen      = 0;
    int full_seen     = 0;
    int cfg_writes    = 0;

    sticky_least_loaded_dispatch_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Works out where a source goes and updates the predictor state as the block would.
    function automatic route_t route_source(input logic [SRC_W-1:0] src);
        route_t r;
        int     free_slot;
        int     n;
        int     best;
        free_slot = SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_taken[i]) begin
                if (slot_src[i] == src) begin
                    r.queue = slot_q[i];
                    r.fresh = 1'b0;
                    r.full  = 1'b0;
                    return r;
                end
            end else if (free_slot == SLOTS) begin
                free_slot = i;
            end
        end
        // A zero count still leaves queue 0; counts above the queue total saturate.
        n = (active_cfg == '0) ? 1 : ((int'(active_cfg) > QUEUES) ? QUEUES : int'(active_cfg));
        best = 0;
        for (int i = 1; i < n; i++) begin
            if (q_load[i] < q_load[best]) best = i;
        end
        r.queue = QIDX_W'(best);
        if (free_slot == SLOTS) begin
            r.fresh = 1'b0;
            r.full  = 1'b1;
            return r;
        end
        slot_taken[free_slot] = 1'b1;
        slot_src[free_slot]   = src;
        slot_q[free_slot]     = QIDX_W'(best);
        if (q_load[best] < LOAD_MAX) q_load[best] = q_load[best] + LOAD_W'(1);
        slots_filled++;
        r.fresh = 1'b1;
        r.full  = 1'b0;
        return r;
    endfunction

    function automatic void log_failure(input string msg);
        route_errors++;
        if (route_errors <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    // Appends one row to the directed stimulus table.
    function automatic void add_row(input row_kind_t kind, input logic [SRC_W-1:0] value,
                                    input bit typed, input route_t want);
        dir_row_t row;
        row.kind  = kind;
        row.value = value;
        row.typed = typed;
        row.want  = want;
        directed_rows = {directed_rows, row};
    endfunction

    // Offers one source after a random gap and records what it should produce.
    task automatic send_item(input logic [SRC_W-1:0] src, input bit typed, input route_t want);
        route_t predicted;
        int     gap;
        gap = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= src;
        do @(posedge aclk); while (!s_tready);
        predicted = route_source(src);
        pending_routes = {pending_routes, (typed ? want : predicted)};
        id_pool = {id_pool, src};
        items_sent++;
    endtask

    // The register is only written once every routing result has come back.
    task automatic write_active(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        active_cfg  = value;
        cfg_writes++;
    endtask

    function automatic logic [SRC_W-1:0] pick_source();
        int pick;
        int bitpos;
        pick   = $urandom_range(0, 99);
        bitpos = $urandom_range(0, SRC_W - 1);
        if (pick < 45 && id_pool.size() != 0)
            return id_pool[$urandom_range(0, id_pool.size() - 1)];
        if (pick < 50) return (pick[0]) ? '1 : '0;
        if (pick < 55) return (pick[0]) ? ~(SRC_W'(1) << bitpos) : (SRC_W'(1) << bitpos);
        return SRC_W'($urandom());
    endfunction

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("[sticky_least_loaded_dispatch_unit] ERROR");
        $finish;
    end

    initial begin : receiver
        route_t want;
        route_t seen;
        int     gap;
        @(posedge aresetn);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            seen.queue = m_tdata[QIDX_W-1:0];
            seen.fresh = m_tdata[QIDX_W];
            seen.full  = m_tdata[QIDX_W+1];
            results_seen++;
            if (seen.fresh) fresh_seen++;
            else if (seen.full) full_seen++;
            else hit_seen++;
            if (pending_routes.size() == 0) begin
                log_failure($sformatf("result %h arrived with nothing pending", m_tdata));
            end else begin
                want = pending_routes.pop_front();
                if (seen.queue !== want.queue || seen.fresh !== want.fresh
                        || seen.full !== want.full || m_tdata[OUT_TDATA_W-1:QIDX_W+2] !== '0)
                    log_failure($sformatf(
                        "result %0d: expected queue=%0d new=%0b full=%0b, got tdata=%h",
                        results_seen, want.queue, want.fresh, want.full, m_tdata));
            end
            if (results_seen % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            // Long hold-off while the sender keeps offering, so the input side backs up.
            if (results_seen == 120 || results_seen == 480) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        route_t           none;
        logic [CFG_W-1:0] setting;
        logic [CFG_W-1:0] extremes [4];
        none        = '0;
        extremes[0] = 4'd1;
        extremes[1] = 4'd15;
        extremes[2] = 4'd0;
        extremes[3] = 4'd8;
        active_cfg   = ACTIVE_RST;
        slots_filled = 0;
        for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
        for (int i = 0; i < QUEUES; i++) q_load[i] = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows: typed results right after reset, for a zero and a one-queue
        // count, and for known sources whose queue has since gone inactive.
        add_row(ROW_ITEM, 16'h0000, 1'b1, '{3'd0, 1'b1, 1'b0});
        add_row(ROW_ITEM, 16'h0000, 1'b1, '{3'd0, 1'b0, 1'b0});
        add_row(ROW_ITEM, 16'hFFFF, 1'b1, '{3'd1, 1'b1, 1'b0});
        add_row(ROW_ITEM, 16'hFFFF, 1'b1, '{3'd1, 1'b0, 1'b0});
        add_row(ROW_ITEM, 16'h8000, 1'b1, '{3'd2, 1'b1, 1'b0});
        add_row(ROW_ITEM, 16'h0001, 1'b1, '{3'd3, 1'b1, 1'b0});
        add_row(ROW_CFG,  16'h0000, 1'b0, none);
        add_row(ROW_ITEM, 16'h5555, 1'b1, '{3'd0, 1'b1, 1'b0});
        add_row(ROW_ITEM, 16'hFFFF, 1'b1, '{3'd1, 1'b0, 1'b0});
        add_row(ROW_CFG,  16'h0001, 1'b0, none);
        add_row(ROW_ITEM, 16'hAAAA, 1'b1, '{3'd0, 1'b1, 1'b0});
        add_row(ROW_CFG,  16'h000F, 1'b0, none);
        add_row(ROW_ITEM, 16'h1234, 1'b0, none);
        add_row(ROW_ITEM, 16'h7FFF, 1'b0, none);
        add_row(ROW_ITEM, 16'h0002, 1'b0, none);
        add_row(ROW_CFG,  16'h0008, 1'b0, none);
        add_row(ROW_ITEM, 16'h00FF, 1'b0, none);
        add_row(ROW_ITEM, 16'hFF00, 1'b0, none);
        add_row(ROW_CFG,  16'h0002, 1'b0, none);
        add_row(ROW_ITEM, 16'h8000, 1'b1, '{3'd2, 1'b0, 1'b0});
        add_row(ROW_ITEM, 16'h0004, 1'b0, none);
        add_row(ROW_ITEM, 16'h0008, 1'b0, none);
        add_row(ROW_CFG,  16'h0003, 1'b0, none);
        add_row(ROW_ITEM, 16'h0010, 1'b0, none);
        add_row(ROW_ITEM, 16'h1234, 1'b0, none);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG)
                write_active(directed_rows[k].value[CFG_W-1:0]);
            else
                send_item(directed_rows[k].value, directed_rows[k].typed, directed_rows[k].want);
        end

        // Random phases: the table fills during the first few, after which new sources
        // come back flagged full. Each phase runs under its own queue count.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            setting = (phase < 4) ? extremes[phase] : CFG_W'($urandom_range(0, 15));
            write_active(setting);
            tx_burst = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_item(pick_source(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_routes.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_routes.size() != 0)
            log_failure($sformatf("%0d results never arrived", pending_routes.size()));

        $display("Run covered %0d source items and %0d active_queues writes;",
            items_sent, cfg_writes);
        $display("table slots used: %0d, new assignments: %0d, known-source hits: %0d,",
            slots_filled, fresh_seen, hit_seen);
        $display("table-full replies: %0d, mismatches: %0d.", full_seen, route_errors);
        if (route_errors == 0)
            $display("[sticky_least_loaded_dispatch_unit] OK");
        else
            $display("[sticky_least_loaded_dispatch_unit] ERROR");
        $finish;
    end

endmodule
